/* rtl/pioexe_pkg.sv */
// Shared types, opcode constants and helpers for the ED-prefix I/O execute block.
`default_nettype none

package pioexe_pkg;

  // Opcode decode masks and match values
  localparam logic [7:0] GROUP_MASK = 8'hC7;  // keeps bits 7:6 and 2:0
  localparam logic [7:0] IN_MATCH   = 8'h40;  // IN r,(C) / IN (C)
  localparam logic [7:0] OUT_MATCH  = 8'h41;  // OUT (C),r / OUT (C),0
  localparam logic [7:0] BLK_MASK   = 8'hE4;
  localparam logic [7:0] BLK_MATCH  = 8'hA0;  // plus bit 1 set: INI..OTDR

  // Bit positions inside the opcode
  localparam int unsigned OPC_BLK_IO  = 1;  // set for every block I/O op
  localparam int unsigned OPC_OUTDIR  = 0;  // block op writes a port
  localparam int unsigned OPC_DOWN    = 3;  // block op walks H:L down
  localparam int unsigned OPC_REPEAT  = 4;  // repeating form

  // Register field codes (cmd[5:3])
  localparam logic [2:0] REG_B    = 3'd0;
  localparam logic [2:0] REG_C    = 3'd1;
  localparam logic [2:0] REG_D    = 3'd2;
  localparam logic [2:0] REG_E    = 3'd3;
  localparam logic [2:0] REG_H    = 3'd4;
  localparam logic [2:0] REG_L    = 3'd5;
  localparam logic [2:0] REG_NONE = 3'd6;  // IN (C) / OUT (C),0
  localparam logic [2:0] REG_A    = 3'd7;

  // Flag bit positions
  localparam int unsigned FLAG_S  = 7;
  localparam int unsigned FLAG_Z  = 6;
  localparam int unsigned FLAG_H  = 4;
  localparam int unsigned FLAG_PV = 2;
  localparam int unsigned FLAG_N  = 1;

  typedef struct packed {
    logic [7:0]  cmd;
    logic [7:0]  reg_a;
    logic [7:0]  reg_b;
    logic [7:0]  reg_c;
    logic [7:0]  reg_d;
    logic [7:0]  reg_e;
    logic [7:0]  reg_h;
    logic [7:0]  reg_l;
    logic [7:0]  flags_in;
    logic [15:0] pc_in;
    logic [7:0]  port_in;
    logic [7:0]  mem_in;
  } in_item_t;

  typedef struct packed {
    logic        reg_write_en;
    logic [2:0]  reg_index;
    logic [7:0]  reg_value;
    logic [7:0]  new_b;
    logic [15:0] new_hl;
    logic [7:0]  flags_out;
    logic [15:0] pc_out;
    logic        mem_write_en;
    logic [15:0] mem_addr;
    logic        port_write_en;
    logic [7:0]  port_addr;
    logic [7:0]  write_data;
  } out_item_t;

  // 1 when the byte has an even number of ones
  function automatic logic even_parity(input logic [7:0] v);
    even_parity = ~(^v);
  endfunction

endpackage

`default_nettype wire

/* rtl/pioexe_if.sv */
// Valid/ready channel interfaces for instructions in and results out.
`default_nettype none

interface pioexe_in_if;
  logic                 valid;
  logic                 ready;
  pioexe_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pioexe_out_if;
  logic                  valid;
  logic                  ready;
  pioexe_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/pioexe_exec.sv */
// Combinational execute of one ED-prefix I/O instruction.
`default_nettype none

module pioexe_exec (
  input  pioexe_pkg::in_item_t  item,
  output pioexe_pkg::out_item_t res
);

  logic [2:0]  field;
  logic [15:0] hl;
  logic        is_in;
  logic        is_out;
  logic        is_blk;
  logic [7:0]  out_reg;
  logic [7:0]  b_dec;

  assign field  = item.cmd[5:3];
  assign hl     = {item.reg_h, item.reg_l};
  assign is_in  = (item.cmd & pioexe_pkg::GROUP_MASK) == pioexe_pkg::IN_MATCH;
  assign is_out = (item.cmd & pioexe_pkg::GROUP_MASK) == pioexe_pkg::OUT_MATCH;
  assign is_blk = ((item.cmd & pioexe_pkg::BLK_MASK) == pioexe_pkg::BLK_MATCH)
                  && item.cmd[pioexe_pkg::OPC_BLK_IO];
  assign b_dec  = item.reg_b - 8'd1;

  always_comb begin
    case (field)
      pioexe_pkg::REG_B: out_reg = item.reg_b;
      pioexe_pkg::REG_C: out_reg = item.reg_c;
      pioexe_pkg::REG_D: out_reg = item.reg_d;
      pioexe_pkg::REG_E: out_reg = item.reg_e;
      pioexe_pkg::REG_H: out_reg = item.reg_h;
      pioexe_pkg::REG_L: out_reg = item.reg_l;
      pioexe_pkg::REG_A: out_reg = item.reg_a;
      default:           out_reg = 8'h00;  // OUT (C),0
    endcase
  end

  always_comb begin
    res.reg_write_en  = 1'b0;
    res.reg_index     = 3'd0;
    res.reg_value     = 8'h00;
    res.new_b         = item.reg_b;
    res.new_hl        = hl;
    res.flags_out     = item.flags_in;
    res.pc_out        = item.pc_in;
    res.mem_write_en  = 1'b0;
    res.mem_addr      = hl;
    res.port_write_en = 1'b0;
    res.port_addr     = item.reg_c;
    res.write_data    = 8'h00;

    if (is_in) begin
      res.flags_out[pioexe_pkg::FLAG_S]  = item.port_in[7];
      res.flags_out[pioexe_pkg::FLAG_Z]  = (item.port_in == 8'h00);
      res.flags_out[pioexe_pkg::FLAG_H]  = 1'b0;
      res.flags_out[pioexe_pkg::FLAG_PV] = pioexe_pkg::even_parity(item.port_in);
      res.flags_out[pioexe_pkg::FLAG_N]  = 1'b0;
      if (field != pioexe_pkg::REG_NONE) begin
        res.reg_write_en = 1'b1;
        res.reg_index    = field;
        res.reg_value    = item.port_in;
      end
    end else if (is_out) begin
      res.port_write_en = 1'b1;
      res.write_data    = out_reg;
    end else if (is_blk) begin
      if (item.cmd[pioexe_pkg::OPC_OUTDIR]) begin
        res.port_write_en = 1'b1;
        res.write_data    = item.mem_in;
      end else begin
        res.mem_write_en = 1'b1;
        res.write_data   = item.port_in;
      end
      res.new_b  = b_dec;
      res.new_hl = item.cmd[pioexe_pkg::OPC_DOWN] ? hl - 16'd1 : hl + 16'd1;
      res.flags_out[pioexe_pkg::FLAG_N] = 1'b1;
      res.flags_out[pioexe_pkg::FLAG_Z] = (b_dec == 8'h00);
      if (b_dec != 8'h00 && item.cmd[pioexe_pkg::OPC_REPEAT]) begin
        res.pc_out = item.pc_in - 16'd2;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/prefixed_io_instruction_execute_top.sv */
// Top level: registered execute stage for the ED-prefix I/O instruction group.
//
// Usage:
//   instr  - sink channel. One transfer carries the second opcode byte after ED,
//            the current A,B,C,D,E,H,L, flags, PC after fetch, the byte read
//            from port C and the byte at H:L.
//   result - source channel. One transfer per instruction: register write
//            request, new B, new H:L, new flags, next PC, memory write and
//            port write requests with address and data.
//   Timing: an instr transfer loads the input register; the result register
//            then takes the decode/flag logic output and raises result valid.
//   Throughput: 1 instruction per cycle while result.ready is high; the two
//            registers form a pipeline whose stages advance whenever the
//            stage ahead is empty or drains.
//   Stall: with result.ready low, the result register holds its transfer,
//            the input register takes one more instruction if it is empty,
//            then instr.ready drops until the receiver takes the result.
//   Reset: rst (synchronous, active high) empties both stages; no
//            instruction state is kept between transfers.
//   Opcodes outside the I/O group pass the inputs through with no write.
`default_nettype none

module prefixed_io_instruction_execute_top (
  input  wire logic         clk,
  input  wire logic         rst,
  pioexe_in_if.sink         instr,
  pioexe_out_if.source      result
);

  // Input stage
  logic                  s0_valid;
  pioexe_pkg::in_item_t  s0_data;
  // Result stage
  logic                  s1_valid;
  pioexe_pkg::out_item_t s1_data;

  pioexe_pkg::out_item_t exec_res;
  logic                  s1_free;
  logic                  s0_free;

  assign s1_free = !s1_valid || result.ready;
  assign s0_free = !s0_valid || s1_free;

  assign instr.ready  = s0_free;
  assign result.valid = s1_valid;
  assign result.data  = s1_data;

  pioexe_exec u_exec (
    .item (s0_data),
    .res  (exec_res)
  );

  // Control: valid bits advance when the next stage can take them
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      if (s0_free) begin
        s0_valid <= instr.valid;
      end
      if (s1_free) begin
        s1_valid <= s0_valid;
      end
    end
  end

  // Payload: loaded only on a move, no reset needed
  always_ff @(posedge clk) begin
    if (s0_free && instr.valid) begin
      s0_data <= instr.data;
    end
    if (s1_free && s0_valid) begin
      s1_data <= exec_res;
    end
  end

endmodule

`default_nettype wire

/* rtl/pioexe_checker.sv */
// Port-level assertions for the I/O execute top, attached by bind.
`default_nettype none

module pioexe_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  res_valid,
  input wire logic                  res_ready,
  input wire pioexe_pkg::out_item_t res_data
);

  // Result stage empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("stalled result changed or dropped");

  // At most one write target per instruction
  a_one_target: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $onehot0({res_data.reg_write_en, res_data.mem_write_en,
                            res_data.port_write_en}))
    else $error("more than one write request");

  // No register write for IN (C), and no data without a write
  a_write_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!res_data.reg_write_en || res_data.reg_index != pioexe_pkg::REG_NONE)
              && (res_data.mem_write_en || res_data.port_write_en
                  || res_data.write_data == 8'h00))
    else $error("inconsistent write fields");

endmodule

bind prefixed_io_instruction_execute_top pioexe_checker u_pioexe_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_data  (result.data)
);

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the ED-prefix I/O execute block: queued driver, monitor, predictor.
`timescale 1ns / 1ps

module testbench;

  // Block I/O opcodes (second byte after ED)
  localparam logic [7:0] OP_INI  = 8'hA2;
  localparam logic [7:0] OP_IND  = 8'hAA;
  localparam logic [7:0] OP_OUTI = 8'hA3;
  localparam logic [7:0] OP_OUTD = 8'hAB;
  localparam logic [7:0] OP_INIR = 8'hB2;
  localparam logic [7:0] OP_INDR = 8'hBA;
  localparam logic [7:0] OP_OTIR = 8'hB3;
  localparam logic [7:0] OP_OTDR = 8'hBB;
  // Opcodes outside the I/O group, used for the pass-through corners
  localparam logic [7:0] OP_NONIO_LO = 8'h00;
  localparam logic [7:0] OP_NONIO_HI = 8'hFF;

  localparam int unsigned RANDOM_ITEMS = 1250;
  // Cap on simulated cycles, so that a hung run stops instead of running on.
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;  // idle wait after the last expected result, to catch a stray one

  logic clk = 1'b0;
  logic rst = 1'b1;

  pioexe_in_if  instr_ch ();
  pioexe_out_if result_ch ();

  prefixed_io_instruction_execute_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_ch),
    .result (result_ch)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pioexe_pkg::in_item_t  pending_instrs[$];    // instructions not yet offered
  pioexe_pkg::out_item_t expected_results[$];  // predicted results, oldest first
  int unsigned total_instrs  = 0;
  int unsigned issued_instrs = 0;
  int unsigned result_index  = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count   = 0;
  logic        instr_taken   = 1'b0;  // transfer on instr at the last rising edge

  // ---------------------------------------------------------------------------
  // Predictor: next-state of registers, flags, PC and write requests for one
  // instruction. Pure function, the block keeps nothing between transfers.
  // ---------------------------------------------------------------------------
  function automatic pioexe_pkg::out_item_t predict_io_exec(input pioexe_pkg::in_item_t x);
    pioexe_pkg::out_item_t r;
    logic [2:0]  fld;
    logic [15:0] hl;
    logic        to_port;
    logic        walk_down;
    logic        repeating;
    fld = x.cmd[5:3];
    hl  = {x.reg_h, x.reg_l};

    r               = '0;
    r.new_b         = x.reg_b;
    r.new_hl        = hl;
    r.flags_out     = x.flags_in;
    r.pc_out        = x.pc_in;
    r.mem_addr      = hl;        // always the H:L before execution
    r.port_addr     = x.reg_c;   // always C

    if ((x.cmd & pioexe_pkg::GROUP_MASK) == pioexe_pkg::IN_MATCH) begin
      // IN r,(C) / IN (C): flags from the port byte, C and bits 5/3 kept
      r.flags_out[pioexe_pkg::FLAG_S]  = x.port_in[7];
      r.flags_out[pioexe_pkg::FLAG_Z]  = (x.port_in == 8'h00);
      r.flags_out[pioexe_pkg::FLAG_H]  = 1'b0;
      r.flags_out[pioexe_pkg::FLAG_PV] = ~^x.port_in;
      r.flags_out[pioexe_pkg::FLAG_N]  = 1'b0;
      if (fld != pioexe_pkg::REG_NONE) begin
        r.reg_write_en = 1'b1;
        r.reg_index    = fld;
        r.reg_value    = x.port_in;
      end
    end else if ((x.cmd & pioexe_pkg::GROUP_MASK) == pioexe_pkg::OUT_MATCH) begin
      r.port_write_en = 1'b1;
      case (fld)
        pioexe_pkg::REG_B: r.write_data = x.reg_b;
        pioexe_pkg::REG_C: r.write_data = x.reg_c;
        pioexe_pkg::REG_D: r.write_data = x.reg_d;
        pioexe_pkg::REG_E: r.write_data = x.reg_e;
        pioexe_pkg::REG_H: r.write_data = x.reg_h;
        pioexe_pkg::REG_L: r.write_data = x.reg_l;
        pioexe_pkg::REG_A: r.write_data = x.reg_a;
        default:           r.write_data = 8'h00;  // OUT (C),0
      endcase
    end else if ((x.cmd & pioexe_pkg::BLK_MASK) == pioexe_pkg::BLK_MATCH
                 && x.cmd[pioexe_pkg::OPC_BLK_IO]) begin
      to_port   = x.cmd[pioexe_pkg::OPC_OUTDIR];
      walk_down = x.cmd[pioexe_pkg::OPC_DOWN];
      repeating = x.cmd[pioexe_pkg::OPC_REPEAT];
      if (to_port) begin
        r.port_write_en = 1'b1;
        r.write_data    = x.mem_in;
      end else begin
        r.mem_write_en  = 1'b1;
        r.write_data    = x.port_in;
      end
      r.new_b  = x.reg_b - 8'd1;
      r.new_hl = walk_down ? hl - 16'd1 : hl + 16'd1;
      r.flags_out[pioexe_pkg::FLAG_N] = 1'b1;
      r.flags_out[pioexe_pkg::FLAG_Z] = (r.new_b == 8'h00);
      // repeat forms rewind over the ED xx pair while B has not run out
      if (repeating && r.new_b != 8'h00) r.pc_out = x.pc_in - 16'd2;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got 0x%0h expected 0x%0h",
                                result_index, name, got, want));
  endtask

  task automatic compare_result(input pioexe_pkg::out_item_t got,
                                input pioexe_pkg::out_item_t want);
    check_field("reg_write_en",  16'(got.reg_write_en),  16'(want.reg_write_en));
    check_field("reg_index",     16'(got.reg_index),     16'(want.reg_index));
    check_field("reg_value",     16'(got.reg_value),     16'(want.reg_value));
    check_field("new_b",         16'(got.new_b),         16'(want.new_b));
    check_field("new_hl",        got.new_hl,             want.new_hl);
    check_field("flags_out",     16'(got.flags_out),     16'(want.flags_out));
    check_field("pc_out",        got.pc_out,             want.pc_out);
    check_field("mem_write_en",  16'(got.mem_write_en),  16'(want.mem_write_en));
    check_field("mem_addr",      got.mem_addr,           want.mem_addr);
    check_field("port_write_en", 16'(got.port_write_en), 16'(want.port_write_en));
    check_field("port_addr",     16'(got.port_addr),     16'(want.port_addr));
    check_field("write_data",    16'(got.write_data),    16'(want.write_data));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] block_opcode(input int unsigned k);
    case (k % 8)
      0:       return OP_INI;
      1:       return OP_IND;
      2:       return OP_OUTI;
      3:       return OP_OUTD;
      4:       return OP_INIR;
      5:       return OP_INDR;
      6:       return OP_OTIR;
      default: return OP_OTDR;
    endcase
  endfunction

  function automatic pioexe_pkg::in_item_t rand_fields();
    pioexe_pkg::in_item_t x;
    x.cmd      = 8'($urandom);
    x.reg_a    = 8'($urandom);
    x.reg_b    = 8'($urandom);
    x.reg_c    = 8'($urandom);
    x.reg_d    = 8'($urandom);
    x.reg_e    = 8'($urandom);
    x.reg_h    = 8'($urandom);
    x.reg_l    = 8'($urandom);
    x.flags_in = 8'($urandom);
    x.pc_in    = 16'($urandom);
    x.port_in  = 8'($urandom);
    x.mem_in   = 8'($urandom);
    return x;
  endfunction

  // Mostly I/O-group opcodes with random operands, with the corners that
  // matter (B near zero, H:L and PC at the wrap points, zero port byte)
  // pulled in more often than plain random values would.
  function automatic pioexe_pkg::in_item_t random_instr();
    pioexe_pkg::in_item_t x;
    int unsigned pick;
    logic [2:0]  fld;
    x    = rand_fields();
    fld  = 3'($urandom_range(7));
    pick = $urandom_range(99);
    if (pick < 25)      x.cmd = pioexe_pkg::IN_MATCH  | {2'b00, fld, 3'b000};
    else if (pick < 45) x.cmd = pioexe_pkg::OUT_MATCH | {2'b00, fld, 3'b000};
    else if (pick < 80) x.cmd = block_opcode($urandom_range(7));
    // otherwise keep the random byte: mostly no-ops, sometimes a group member

    if ($urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0:       x.reg_b = 8'h00;
        1:       x.reg_b = 8'h01;
        2:       x.reg_b = 8'h02;
        default: x.reg_b = 8'hFF;
      endcase
    end
    if ($urandom_range(7) == 0) {x.reg_h, x.reg_l} = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(2))
        0:       x.pc_in = 16'h0000;
        1:       x.pc_in = 16'h0001;
        default: x.pc_in = 16'hFFFF;
      endcase
    end
    if ($urandom_range(7) == 0) x.port_in = 8'h00;
    return x;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers pending instructions and drives result.ready, all on the
  // falling edge. Idle rates follow the run phase: receiver-heavy idling, then
  // sender-heavy, then none at all.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    if (issued_instrs < total_instrs / 3) begin
      send_idle_pct = 32;
      recv_idle_pct = 46;
    end else if (issued_instrs < (2 * total_instrs) / 3) begin
      send_idle_pct = 46;
      recv_idle_pct = 32;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end

    if (rst) begin
      instr_ch.valid  <= 1'b0;
      result_ch.ready <= 1'b0;
    end else begin
      // hold the current offer until its transfer; then maybe idle before the next
      if (!instr_ch.valid || instr_taken) begin
        if (pending_instrs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          instr_ch.data  <= pending_instrs.pop_front();
          instr_ch.valid <= 1'b1;
          issued_instrs++;
        end else begin
          instr_ch.valid <= 1'b0;
        end
      end
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: on the rising edge, predict each accepted instruction and check
  // each accepted result against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    instr_taken <= !rst && instr_ch.valid && instr_ch.ready;
    if (!rst) begin
      if (instr_ch.valid && instr_ch.ready)
        expected_results.push_back(predict_io_exec(instr_ch.data));
      if (result_ch.valid && result_ch.ready) begin
        if (expected_results.size() == 0)
          report_mismatch($sformatf("result %0d arrived with nothing expected",
                                    result_index));
        else
          compare_result(result_ch.data, expected_results.pop_front());
        result_index++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: fill the queue, release reset, wait for the last transfer.
  // ---------------------------------------------------------------------------
  initial begin
    pioexe_pkg::in_item_t it;
    int unsigned k;
    instr_ch.valid  = 1'b0;
    instr_ch.data   = '0;
    result_ch.ready = 1'b0;

    // IN r,(C) for every field, IN (C) among them; zero, all-ones and
    // sign-bit port bytes, flags in all set and all clear
    for (k = 0; k < 8; k++) begin
      it          = rand_fields();
      it.cmd      = pioexe_pkg::IN_MATCH | {2'b00, 3'(k), 3'b000};
      it.flags_in = k[0] ? 8'hFF : 8'h00;
      case (k)
        0, 6:    it.port_in = 8'h00;
        1:       it.port_in = 8'hFF;
        2:       it.port_in = 8'h80;
        default: it.port_in = 8'($urandom);
      endcase
      pending_instrs.push_back(it);
    end

    // OUT (C),r for every field, OUT (C),0 among them
    for (k = 0; k < 8; k++) begin
      it     = rand_fields();
      it.cmd = pioexe_pkg::OUT_MATCH | {2'b00, 3'(k), 3'b000};
      pending_instrs.push_back(it);
    end

    // Block ops: B ending at zero, B wrapping from zero, repeats with PC
    // wrapping below zero, H:L wrapping both ways
    for (k = 0; k < 8; k++) begin
      it     = rand_fields();
      it.cmd = block_opcode(k);
      case (k % 4)
        0:       it.reg_b = 8'h01;
        1:       it.reg_b = 8'h00;
        2:       it.reg_b = 8'h02;
        default: it.reg_b = 8'hFF;
      endcase
      {it.reg_h, it.reg_l} = k[0] ? 16'h0000 : 16'hFFFF;  // odd k walk down
      it.pc_in             = k[0] ? 16'h0001 : 16'h0000;
      pending_instrs.push_back(it);
    end

    // Opcodes outside the group with every operand at its extreme
    it     = '0;
    it.cmd = OP_NONIO_LO;
    pending_instrs.push_back(it);
    it     = '1;
    it.cmd = OP_NONIO_HI;
    pending_instrs.push_back(it);

    for (k = 0; k < RANDOM_ITEMS; k++) pending_instrs.push_back(random_instr());
    total_instrs = pending_instrs.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while ((pending_instrs.size() != 0 || instr_ch.valid || expected_results.size() != 0)
           && cycle_count < CYCLE_LIMIT)
      @(posedge clk);

    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
    end else begin
      // a little extra time so a stray result would still be caught
      repeat (DRAIN_CYCLES) @(posedge clk);
      #0.1;
      if (expected_results.size() != 0)
        report_mismatch($sformatf("%0d expected results never arrived",
                                  expected_results.size()));
      if (mismatch_count == 0) begin
        $display("ALL CHECKS PASSED");
      end else begin
        $display("CHECKS FAILED");
      end
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/pioexe_pkg.sv
rtl/pioexe_if.sv
rtl/pioexe_exec.sv
rtl/prefixed_io_instruction_execute_top.sv
rtl/pioexe_checker.sv
bench/testbench.sv
